FILE: src/fskdf_pkg.sv
package fskdf_pkg;

  localparam int NumTones = 4;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_LEVEL_THRESHOLD = 3'd0,
    CFG_STEP_SIZE       = 3'd1,
    CFG_HIGH_NEEDED     = 3'd2,
    CFG_LOW_NEEDED      = 3'd3,
    CFG_TONE1_STEP      = 3'd4,
    CFG_TONE2_STEP      = 3'd5,
    CFG_TONE3_STEP      = 3'd6,
    CFG_TONE4_STEP      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [14:0]                level_threshold;
    logic [15:0]                step_size;
    logic [15:0]                high_needed;
    logic [15:0]                low_needed;
    logic [NumTones-1:0][15:0]  tone_step;
  } cfg_t;

  // queued sample with its phase index
  typedef struct packed {
    logic               valid;
    logic signed [15:0] sample;
    logic [15:0]        phase;
  } smp_t;

  // per-sample tone end report
  typedef struct packed {
    logic                valid;
    logic [NumTones-1:0] ended;
  } sym_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ACTIVE = 2'd1,
    MODE_ENDED  = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_RDSIN,
    ST_RDCOS,
    ST_YCOS,
    ST_YSIN,
    ST_ERR,
    ST_MUSIN,
    ST_WCOS,
    ST_WSIN,
    ST_REPORT
  } step_e;

  // quarter-wave sine magnitude in Q1.14, evaluated at elaboration
  function automatic logic [14:0] quarter_sine(input int unsigned idx, input int unsigned qb);
    longint x;
    longint x2;
    longint t;
    x  = longint'(idx) << (16 - qb);
    x2 = (x * x) >> 16;
    t  = 42048 - ((x2 * 4640) >> 16);
    t  = 102944 - ((x2 * t) >> 16);
    return 15'(((x * t) >> 16) >> 2);
  endfunction

endpackage

FILE: src/fskdf_sine_rom.sv
module fskdf_sine_rom #(
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic                       clk_i,
  input  logic [TABLE_ADDR_BITS-1:0] addr_i,
  output logic signed [15:0]         data_o
);
  import fskdf_pkg::*;

  localparam int unsigned Qb = TABLE_ADDR_BITS - 2;
  localparam int unsigned Qn = 1 << Qb;

  logic [14:0] table_w [Qn+1];
  logic [Qb:0] idx;
  logic [14:0] mag_q;
  logic        neg_q;

  // quarter-wave table constants
  for (genvar g = 0; g <= Qn; g++) begin : g_tab
    assign table_w[g] = quarter_sine(g, Qb);
  end

  // fold the address into the first quadrant
  always_comb begin
    if (addr_i[Qb]) begin
      idx = (Qb+1)'(Qn) - {1'b0, addr_i[Qb-1:0]};
    end else begin
      idx = {1'b0, addr_i[Qb-1:0]};
    end
  end

  // registered table read
  always_ff @(posedge clk_i) begin
    mag_q <= table_w[idx];
    neg_q <= addr_i[Qb+1];
  end

  assign data_o = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

endmodule

FILE: src/fskdf_front.sv
module fskdf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  sample_i,
  input  logic                buffer_start_i,
  output fskdf_pkg::smp_t     head_o,
  input  logic                pop_i
);
  import fskdf_pkg::*;

  logic [15:0]        phase_q, phase_d;
  logic signed [15:0] ent_sample_q [2];
  logic [15:0]        ent_phase_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         count_q;
  logic               push, pop;
  logic [15:0]        kidx;

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (count_q != 2'd0);

  // phase index for this sample
  assign kidx    = buffer_start_i ? 16'd0 : phase_q;
  assign phase_d = kidx + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) begin
        phase_q  <= phase_d;
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  // queue entries
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_sample_q[wr_ptr_q] <= sample_i;
      ent_phase_q[wr_ptr_q]  <= kidx;
    end
  end

  assign head_o.valid  = (count_q != 2'd0);
  assign head_o.sample = ent_sample_q[rd_ptr_q];
  assign head_o.phase  = ent_phase_q[rd_ptr_q];

endmodule

FILE: src/fskdf_filter.sv
module fskdf_filter #(
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fskdf_pkg::cfg_t  cfg_i,
  input  fskdf_pkg::smp_t  head_i,
  output logic             pop_o,
  output fskdf_pkg::sym_t  sym_o,
  input  logic             sym_ready_i
);
  import fskdf_pkg::*;

  localparam int unsigned Qn = 1 << (TABLE_ADDR_BITS - 2);

  step_e              state_q, state_d;
  logic [1:0]         tone_q;
  logic signed [15:0] sample_q;
  logic [15:0]        kidx_q;
  logic [15:0]        ph_q;
  logic signed [15:0] xs_q, xc_q;
  logic signed [47:0] acc_q;
  logic signed [34:0] y_q;
  logic signed [31:0] e_q;
  logic               hi_q;
  logic signed [31:0] pc_q, ps_q;
  logic signed [31:0] wc_q [NumTones];
  logic signed [31:0] ws_q [NumTones];
  mode_e              mode_q [NumTones];
  logic [15:0]        ht_q [NumTones];
  logic [15:0]        lt_q [NumTones];

  logic [TABLE_ADDR_BITS-1:0] rom_addr;
  logic signed [15:0]         rom_data;
  logic signed [31:0]         mul_a, mul_b;
  logic signed [63:0]         prod;
  logic signed [48:0]         ysum;
  logic signed [27:0]         dval;
  logic signed [35:0]         diff;
  logic [34:0]                mag;
  logic signed [33:0]         upd;
  logic signed [34:0]         wsum;
  mode_e                      m_d;
  logic [15:0]                ht_d, lt_d;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  fskdf_sine_rom #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // sine address then cosine address one quarter turn later
  always_comb begin
    if (state_q == ST_RDCOS) begin
      rom_addr = ph_q[15 -: TABLE_ADDR_BITS] + TABLE_ADDR_BITS'(Qn);
    end else begin
      rom_addr = ph_q[15 -: TABLE_ADDR_BITS];
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PHASE: begin
        mul_a = $signed({16'd0, kidx_q});
        mul_b = $signed({16'd0, cfg_i.tone_step[tone_q]});
      end
      ST_YCOS: begin
        mul_a = wc_q[tone_q];
        mul_b = 32'(rom_data);
      end
      ST_YSIN: begin
        mul_a = ws_q[tone_q];
        mul_b = 32'(xs_q);
      end
      ST_ERR: begin
        mul_a = $signed({16'd0, cfg_i.step_size});
        mul_b = 32'(xc_q);
      end
      ST_MUSIN: begin
        mul_a = $signed({16'd0, cfg_i.step_size});
        mul_b = 32'(xs_q);
      end
      ST_WCOS: begin
        mul_a = pc_q;
        mul_b = e_q;
      end
      ST_WSIN: begin
        mul_a = ps_q;
        mul_b = e_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // filter output, error and level
  assign ysum = 49'(acc_q) + 49'(prod);
  assign dval = $signed({sample_q, 12'd0});
  assign diff = 36'(dval) - 36'(y_q);
  assign mag  = y_q[34] ? 35'(-y_q) : 35'(y_q);

  // weight update
  assign upd = 34'(prod >>> 30);
  always_comb begin
    if (state_q == ST_WCOS) begin
      wsum = 35'(wc_q[tone_q]) + 35'(upd);
    end else begin
      wsum = 35'(ws_q[tone_q]) + 35'(upd);
    end
  end

  // idle, active, ended detector
  always_comb begin
    m_d  = mode_q[tone_q];
    ht_d = ht_q[tone_q];
    lt_d = lt_q[tone_q];
    case (mode_q[tone_q])
      MODE_IDLE: begin
        if (hi_q) begin
          if (ht_q[tone_q] != 16'hFFFF) begin
            ht_d = ht_q[tone_q] + 16'd1;
          end
          if (ht_d >= cfg_i.high_needed) begin
            m_d = MODE_ACTIVE;
          end
        end
      end
      MODE_ACTIVE: begin
        if (!hi_q) begin
          if (lt_q[tone_q] != 16'hFFFF) begin
            lt_d = lt_q[tone_q] + 16'd1;
          end
          if (lt_d >= cfg_i.low_needed) begin
            m_d = MODE_ENDED;
          end
        end
      end
      default: begin
        m_d  = MODE_IDLE;
        ht_d = '0;
        lt_d = '0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (head_i.valid) state_d = ST_PHASE;
      ST_PHASE:  state_d = ST_RDSIN;
      ST_RDSIN:  state_d = ST_RDCOS;
      ST_RDCOS:  state_d = ST_YCOS;
      ST_YCOS:   state_d = ST_YSIN;
      ST_YSIN:   state_d = ST_ERR;
      ST_ERR:    state_d = ST_MUSIN;
      ST_MUSIN:  state_d = ST_WCOS;
      ST_WCOS:   state_d = ST_WSIN;
      ST_WSIN:   state_d = (tone_q == 2'd3) ? ST_REPORT : ST_PHASE;
      ST_REPORT: if (sym_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tone_q  <= '0;
      for (int t = 0; t < NumTones; t++) begin
        wc_q[t]   <= '0;
        ws_q[t]   <= '0;
        mode_q[t] <= MODE_IDLE;
        ht_q[t]   <= '0;
        lt_q[t]   <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: tone_q <= '0;
        ST_MUSIN: begin
          mode_q[tone_q] <= m_d;
          ht_q[tone_q]   <= ht_d;
          lt_q[tone_q]   <= lt_d;
        end
        ST_WCOS: wc_q[tone_q] <= sat32(36'(wsum));
        ST_WSIN: begin
          ws_q[tone_q] <= sat32(36'(wsum));
          tone_q       <= tone_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sample_q <= head_i.sample;
        kidx_q   <= head_i.phase;
      end
      ST_PHASE: ph_q  <= prod[15:0];
      ST_RDCOS: xs_q  <= rom_data;
      ST_YCOS: begin
        xc_q  <= rom_data;
        acc_q <= prod[47:0];
      end
      ST_YSIN: y_q <= 35'(ysum >>> 14);
      ST_ERR: begin
        e_q  <= sat32(diff);
        hi_q <= (mag >= {8'd0, cfg_i.level_threshold, 12'd0});
        pc_q <= prod[31:0];
      end
      ST_MUSIN: ps_q <= prod[31:0];
      default: ;
    endcase
  end

  assign pop_o     = (state_q == ST_IDLE) && head_i.valid;
  assign sym_o.valid = (state_q == ST_REPORT);
  always_comb begin
    for (int t = 0; t < NumTones; t++) begin
      sym_o.ended[t] = (mode_q[t] == MODE_ENDED);
    end
  end

endmodule

FILE: src/fskdf_framer.sv
module fskdf_framer #(
  parameter int FRAME_BYTES = 10,
  parameter int FRAME_BITS  = 80
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fskdf_pkg::sym_t  sym_i,
  output logic             sym_ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       frame_byte_o,
  output logic [3:0]       byte_number_o,
  output logic             check_good_o,
  output logic             last_o
);
  import fskdf_pkg::*;

  localparam int FrameW = FRAME_BYTES * 8;
  localparam int FillW  = $clog2(FRAME_BITS + 2);

  logic [NumTones-1:0]   pend_q;
  logic                  busy_q;
  logic [1:0]            tone_q;
  logic                  done_q;
  logic [FRAME_BITS-1:0] store_q, store_n;
  logic [FillW-1:0]      fill_q, fill_n;
  logic [FrameW-1:0]     obuf_q, frame;
  logic [3:0]            onum_q;
  logic                  good_q, ovalid_q;
  logic                  cur, full, advance, good, xfer;
  logic [7:0]            xsum;

  assign sym_ready_o = !busy_q;
  assign cur         = pend_q[tone_q];
  assign xfer        = ovalid_q && !out_stall_i;

  // append the two symbol bits, dropping any past the frame end
  always_comb begin
    store_n = store_q;
    if (fill_q < FillW'(FRAME_BITS)) begin
      store_n = {store_n[FRAME_BITS-2:0], tone_q[1]};
    end
    if (fill_q + FillW'(1) < FillW'(FRAME_BITS)) begin
      store_n = {store_n[FRAME_BITS-2:0], tone_q[0]};
    end
    fill_n = fill_q + FillW'(2);
  end

  assign full    = (fill_n >= FillW'(FRAME_BITS)) && !done_q;
  assign advance = !cur || !full || !ovalid_q;

  // byte image of the frame, bits beyond the store read as zero
  always_comb begin
    for (int p = 0; p < FrameW; p++) begin
      frame[FrameW-1-p] = (p < FRAME_BITS) ? store_n[FRAME_BITS-1-p] : 1'b0;
    end
  end

  // xor check over all but the last byte
  always_comb begin
    xsum = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) begin
      xsum = xsum ^ frame[FrameW-1-8*i -: 8];
    end
    good = (xsum == frame[7:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= '0;
      busy_q   <= 1'b0;
      tone_q   <= '0;
      done_q   <= 1'b0;
      store_q  <= '0;
      fill_q   <= '0;
      onum_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      // output byte transfer
      if (xfer) begin
        onum_q <= onum_q + 4'd1;
        if (onum_q == 4'(FRAME_BYTES - 1)) begin
          ovalid_q <= 1'b0;
        end
      end
      if (!busy_q) begin
        if (sym_i.valid) begin
          pend_q <= sym_i.ended;
          busy_q <= 1'b1;
          tone_q <= '0;
          done_q <= 1'b0;
        end
      end else if (advance) begin
        if (cur) begin
          if (full) begin
            store_q  <= '0;
            fill_q   <= '0;
            done_q   <= 1'b1;
            onum_q   <= '0;
            ovalid_q <= 1'b1;
          end else begin
            store_q <= store_n;
            fill_q  <= fill_n;
          end
        end
        if (tone_q == 2'd3) begin
          busy_q <= 1'b0;
        end
        tone_q <= tone_q + 2'd1;
      end
    end
  end

  // frame image load and byte shift
  always_ff @(posedge clk_i) begin
    if (busy_q && advance && cur && full) begin
      obuf_q <= frame;
      good_q <= good;
    end else if (xfer) begin
      obuf_q <= obuf_q << 8;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign frame_byte_o  = obuf_q[FrameW-1 -: 8];
  assign byte_number_o = onum_q;
  assign check_good_o  = good_q;
  assign last_o        = (onum_q == 4'(FRAME_BYTES - 1));

endmodule

FILE: src/four_tone_notch_fsk_deframer.sv
// Four-tone FSK deframer with LMS adaptive notch filters.
// Input channel: in_valid_i / in_stall_o carry one Q4.12 sample and its
// buffer_start flag per transfer. A two-entry queue takes samples while the
// filter engine works, so the sender stalls only when both entries are full.
// For each sample the four tones are run one after another through
// a single shared 32x32 multiplier, nine steps per tone plus a load step and
// a report step.
// Output channel: out_valid_o / out_stall_i carry frame bytes. When the bit
// store fills, FRAME_BYTES bytes follow, one per cycle while not stalled,
// byte_number_o counting from zero and last_o marking the final byte.
// A stalled output holds its byte; symbol collection continues, and only
// the next full frame waits for the output buffer to drain.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i; write only
// while no sample is in flight.
// Reset clears weights, detectors, phase index, bit store and restores the
// default register values; the block is ready right after reset.
module four_tone_notch_fsk_deframer #(
  parameter int FRAME_BYTES     = 10,
  parameter int FRAME_BITS      = 80,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_i,
  input  logic               buffer_start_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         frame_byte_o,
  output logic [3:0]         byte_number_o,
  output logic               check_good_o,
  output logic               last_o
);
  import fskdf_pkg::*;

  cfg_t cfg_q;
  smp_t head;
  sym_t sym;
  logic pop, sym_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_threshold <= 15'd4915;
      cfg_q.step_size       <= 16'd1311;
      cfg_q.high_needed     <= 16'd10;
      cfg_q.low_needed      <= 16'd200;
      cfg_q.tone_step[0]    <= 16'd9437;
      cfg_q.tone_step[1]    <= 16'd10486;
      cfg_q.tone_step[2]    <= 16'd11534;
      cfg_q.tone_step[3]    <= 16'd12583;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LEVEL_THRESHOLD: cfg_q.level_threshold <= cfg_data_i[14:0];
        CFG_STEP_SIZE:       cfg_q.step_size       <= cfg_data_i;
        CFG_HIGH_NEEDED:     cfg_q.high_needed     <= cfg_data_i;
        CFG_LOW_NEEDED:      cfg_q.low_needed      <= cfg_data_i;
        CFG_TONE1_STEP:      cfg_q.tone_step[0]    <= cfg_data_i;
        CFG_TONE2_STEP:      cfg_q.tone_step[1]    <= cfg_data_i;
        CFG_TONE3_STEP:      cfg_q.tone_step[2]    <= cfg_data_i;
        CFG_TONE4_STEP:      cfg_q.tone_step[3]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fskdf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .buffer_start_i (buffer_start_i),
    .head_o         (head),
    .pop_i          (pop)
  );

  fskdf_filter #(
    .TABLE_ADDR_BITS(TABLE_ADDR_BITS)
  ) u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .pop_o       (pop),
    .sym_o       (sym),
    .sym_ready_i (sym_ready)
  );

  fskdf_framer #(
    .FRAME_BYTES(FRAME_BYTES),
    .FRAME_BITS (FRAME_BITS)
  ) u_framer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sym_i         (sym),
    .sym_ready_o   (sym_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_byte_o  (frame_byte_o),
    .byte_number_o (byte_number_o),
    .check_good_o  (check_good_o),
    .last_o        (last_o)
  );

  // bytes of a frame come out back to back in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=>
      out_valid_o && (byte_number_o == 4'($past(byte_number_o) + 4'd1)))
    else $error("frame byte sequence broken");

  // nothing follows the last byte directly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !out_valid_o)
    else $error("output valid after last byte");

  // byte number stays inside the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_number_o < 4'(FRAME_BYTES))
    else $error("byte number beyond frame");

  // a pop of the sample queue is not directly followed by a report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !sym.valid)
    else $error("report raised right after pop");

endmodule
